// ===== rtl/crbf_pkg.sv =====
package crbf_pkg;

    localparam int COLOUR_W    = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 2;

    // R+G+B at or above this is a bright colour (average >= one half)
    localparam logic [9:0] BRIGHT_THRESHOLD = 10'd383;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_PAIR   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_UPDATED  = 2'd1,
        STATUS_APPENDED = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LIGHT_COLOUR  = 2'd0,
        CFG_LIGHT_ENABLED = 2'd1,
        CFG_DARK_COLOUR   = 2'd2,
        CFG_DARK_ENABLED  = 2'd3
    } cfg_index_t;

    // Classified word passed from the front end to the back end
    typedef struct packed {
        kind_t               kind;
        logic [COLOUR_W-1:0] first;
        logic [COLOUR_W-1:0] second;
        logic                bright_first;
        logic                bright_second;
    } item_t;

    function automatic logic is_bright(input logic [COLOUR_W-1:0] c);
        logic [9:0] sum;
        sum = 10'(c[31:24]) + 10'(c[23:16]) + 10'(c[15:8]);
        return sum >= BRIGHT_THRESHOLD;
    endfunction

endpackage

// ===== rtl/colour_remap_with_brightness_fallback.sv =====
// An accepted word passes through the input queue, the lookup state (S_IDLE)
// with the registered read of the replacement memory, the resolve state
// (S_RESOLVE) and the output register; the next word is popped only in S_IDLE.
// The 2-word input queue takes words while a result waits on m_tready, up to full.
// Reset (aresetn low, synchronous) empties the queue and the table and clears
// the configuration registers; table contents are not swept.
module colour_remap_with_brightness_fallback #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [crbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crbf_pkg::COLOUR_W-1:0]   cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*crbf_pkg::COLOUR_W-1:0] s_tdata,  // first_colour, second_colour
    input  logic [crbf_pkg::KIND_W-1:0]     s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*crbf_pkg::COLOUR_W-1:0] m_tdata,  // first_result, second_result
    output logic [crbf_pkg::STATUS_W:0]     m_tuser   // was_replaced, status
);
    import crbf_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    crbf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    crbf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/crbf_front.sv =====
module crbf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*crbf_pkg::COLOUR_W-1:0] s_tdata,  // first_colour, second_colour
    input  logic [crbf_pkg::KIND_W-1:0]   s_tuser,  // kind
    output logic                          q_valid,
    output crbf_pkg::item_t               q_item,
    input  logic                          q_pop
);
    import crbf_pkg::*;

    item_t      slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    item_t      item_in;

    // Classify the incoming word
    always_comb begin
        item_in.kind          = kind_t'(s_tuser);
        item_in.first         = s_tdata[COLOUR_W-1:0];
        item_in.second        = s_tdata[2*COLOUR_W-1:COLOUR_W];
        item_in.bright_first  = is_bright(s_tdata[COLOUR_W-1:0]);
        item_in.bright_second = is_bright(s_tdata[2*COLOUR_W-1:COLOUR_W]);
    end

    assign s_tready = fill_reg != 2'(QUEUE_DEPTH);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = fill_reg != 2'd0;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !q_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && q_pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Advance queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Hold queued words
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== rtl/crbf_back.sv =====
module crbf_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [crbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crbf_pkg::COLOUR_W-1:0]   cfg_wdata,
    input  logic                            q_valid,
    input  crbf_pkg::item_t                 q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*crbf_pkg::COLOUR_W-1:0] m_tdata,  // first_result, second_result
    output logic [crbf_pkg::STATUS_W:0]     m_tuser   // was_replaced, status
);
    import crbf_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } state_t;

    typedef enum logic [1:0] {
        FB_NONE,
        FB_LIGHT,
        FB_DARK
    } fb_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                m_tvalid_reg;
    logic [COLOUR_W-1:0] first_res_reg;
    logic [COLOUR_W-1:0] second_res_reg;
    logic                replaced_reg;
    status_t             status_out_reg;

    logic [COLOUR_W-1:0] light_colour_reg;
    logic                light_enabled_reg;
    logic [COLOUR_W-1:0] dark_colour_reg;
    logic                dark_enabled_reg;

    item_t               item_reg;
    logic                hit_a_reg;
    logic                hit_b_reg;
    status_t             status_reg;
    logic [COLOUR_W-1:0] rd_a_reg;
    logic [COLOUR_W-1:0] rd_b_reg;

    logic [COLOUR_W-1:0] match_reg [TABLE_ENTRIES];
    logic [COLOUR_W-1:0] repl_mem  [TABLE_ENTRIES];

    logic                hit_a;
    logic                hit_b;
    logic [IDX_W-1:0]    slot_a;
    logic [IDX_W-1:0]    slot_b;
    logic                full;
    logic                is_insert;
    logic                repl_we;
    logic [IDX_W-1:0]    repl_idx;
    logic                match_we;
    status_t             status_next;

    logic [COLOUR_W-1:0] first_res_next;
    logic [COLOUR_W-1:0] second_res_next;
    logic                replaced_next;
    status_t             status_out_next;
    fb_t                 ink_fb;
    logic                paper_bright;
    logic                out_free;

    // Compare both colours against every valid entry, lowest index wins
    always_comb begin
        hit_a  = 1'b0;
        hit_b  = 1'b0;
        slot_a = '0;
        slot_b = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (CNT_W'(i) < count_reg && match_reg[i] == q_item.first) begin
                hit_a  = 1'b1;
                slot_a = IDX_W'(i);
            end
            if (CNT_W'(i) < count_reg && match_reg[i] == q_item.second) begin
                hit_b  = 1'b1;
                slot_b = IDX_W'(i);
            end
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign full      = count_reg == CNT_W'(TABLE_ENTRIES);
    assign is_insert = q_pop && (q_item.kind == KIND_INSERT);

    // Decide the table update for an insert word
    always_comb begin
        repl_we     = 1'b0;
        match_we    = 1'b0;
        repl_idx    = slot_a;
        status_next = STATUS_DONE;
        if (is_insert) begin
            if (hit_a) begin
                repl_we     = 1'b1;
                status_next = STATUS_UPDATED;
            end else if (!full) begin
                repl_we     = 1'b1;
                match_we    = 1'b1;
                repl_idx    = count_reg[IDX_W-1:0];
                status_next = STATUS_APPENDED;
            end else begin
                status_next = STATUS_FULL;
            end
        end
    end

    // Replacement memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (repl_we) begin
            repl_mem[repl_idx] <= q_item.second;
        end
        if (q_pop) begin
            rd_a_reg <= repl_mem[slot_a];
            rd_b_reg <= repl_mem[slot_b];
        end
    end

    // Append match colours
    always_ff @(posedge aclk) begin
        if (match_we) begin
            match_reg[count_reg[IDX_W-1:0]] <= q_item.first;
        end
    end

    // Resolve ink, then paper, from table hits and fallbacks
    always_comb begin
        first_res_next  = item_reg.first;
        second_res_next = item_reg.second;
        replaced_next   = 1'b0;
        status_out_next = STATUS_DONE;
        ink_fb          = FB_NONE;
        paper_bright    = item_reg.bright_second;

        if (item_reg.kind == KIND_SINGLE || item_reg.kind == KIND_PAIR) begin
            if (hit_a_reg) begin
                first_res_next = rd_a_reg;
                replaced_next  = 1'b1;
            end else if (item_reg.bright_first && light_enabled_reg) begin
                first_res_next = light_colour_reg;
                replaced_next  = 1'b1;
                ink_fb         = FB_LIGHT;
            end else if (!item_reg.bright_first && dark_enabled_reg) begin
                first_res_next = dark_colour_reg;
                replaced_next  = 1'b1;
                ink_fb         = FB_DARK;
            end
        end

        case (ink_fb)
            FB_LIGHT: paper_bright = 1'b0;
            FB_DARK:  paper_bright = 1'b1;
            default:  paper_bright = item_reg.bright_second;
        endcase

        if (item_reg.kind == KIND_PAIR) begin
            if (hit_b_reg) begin
                second_res_next = rd_b_reg;
                replaced_next   = 1'b1;
            end else if (paper_bright && light_enabled_reg) begin
                second_res_next = light_colour_reg;
                replaced_next   = 1'b1;
            end else if (!paper_bright && dark_enabled_reg) begin
                second_res_next = dark_colour_reg;
                replaced_next   = 1'b1;
            end
        end

        if (item_reg.kind == KIND_INSERT) begin
            status_out_next = status_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
            light_colour_reg  <= '0;
            light_enabled_reg <= 1'b0;
            dark_colour_reg   <= '0;
            dark_enabled_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_LIGHT_COLOUR:  light_colour_reg  <= cfg_wdata;
                    CFG_LIGHT_ENABLED: light_enabled_reg <= cfg_wdata[0];
                    CFG_DARK_COLOUR:   dark_colour_reg   <= cfg_wdata;
                    CFG_DARK_ENABLED:  dark_enabled_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end

            // Drop the taken result word unless a new one is loaded
            if (m_tvalid_reg && m_tready && state_reg != S_RESOLVE) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg   <= q_item;
                        hit_a_reg  <= hit_a;
                        hit_b_reg  <= hit_b;
                        status_reg <= status_next;
                        if (match_we) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    if (out_free) begin
                        first_res_reg  <= first_res_next;
                        second_res_reg <= second_res_next;
                        replaced_reg   <= replaced_next;
                        status_out_reg <= status_out_next;
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {second_res_reg, first_res_reg};
    assign m_tuser  = {status_out_reg, replaced_reg};

endmodule

// ===== rtl/crbf_checker.sv =====
module crbf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [2*crbf_pkg::COLOUR_W-1:0] m_tdata,
    input logic [crbf_pkg::STATUS_W:0]     m_tuser
);
    import crbf_pkg::*;

    // Stalled result word stays valid
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // Stalled result word keeps its payload
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Table update words never report a replaced colour
    a_insert_no_replace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STATUS_W:1] != STATUS_DONE |-> !m_tuser[0])
        else $error("insert result flagged as replaced");

    // Reset leaves no result word pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind colour_remap_with_brightness_fallback crbf_checker u_crbf_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import crbf_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic [COLOUR_W-1:0] first;
        logic [COLOUR_W-1:0] second;
        logic                replaced;
        status_t             status;
    } remap_word_t;

    typedef enum logic [1:0] {
        FALLBACK_NONE,
        FALLBACK_LIGHT,
        FALLBACK_DARK
    } fallback_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [COLOUR_W-1:0]      cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [2*COLOUR_W-1:0]    s_tdata   = '0;  // first_colour, second_colour
    logic [KIND_W-1:0]        s_tuser   = '0;  // kind
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [2*COLOUR_W-1:0]    m_tdata;         // first_result, second_result
    logic [STATUS_W:0]        m_tuser;         // was_replaced, status

    // Mirror of the substitution table and fallback registers
    logic [COLOUR_W-1:0] tbl_match [TABLE_SLOTS];
    logic [COLOUR_W-1:0] tbl_repl  [TABLE_SLOTS];
    int                  tbl_used;
    logic [COLOUR_W-1:0] light_rgba;
    logic [COLOUR_W-1:0] dark_rgba;
    logic                light_on;
    logic                dark_on;

    remap_word_t         expected_words [$];
    logic [COLOUR_W-1:0] colour_pool [POOL_SIZE];

    int mismatch_count   = 0;
    int words_sent       = 0;
    int table_appends    = 0;
    int table_updates    = 0;
    int table_drops      = 0;
    int colours_replaced = 0;
    int settings_written = 0;
    int stall_left       = 0;
    bit steady           = 1'b0;

    colour_remap_with_brightness_fallback #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("colour_remap_with_brightness_fallback verification failed");
        $finish;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Bright when R+G+B reaches half of full scale; alpha is ignored
    function automatic bit colour_is_light(input logic [COLOUR_W-1:0] c);
        int sum;
        sum = int'(c[31:24]) + int'(c[23:16]) + int'(c[15:8]);
        return sum >= 383;
    endfunction

    function automatic int find_entry(input logic [COLOUR_W-1:0] c);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_match[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic fallback_t pick_fallback(input bit bright,
                                                input logic [COLOUR_W-1:0] c,
                                                output logic [COLOUR_W-1:0] res);
        res = c;
        if (bright && light_on) begin
            res = light_rgba;
            return FALLBACK_LIGHT;
        end
        if (!bright && dark_on) begin
            res = dark_rgba;
            return FALLBACK_DARK;
        end
        return FALLBACK_NONE;
    endfunction

    // Work out the result word of one input word and update the table mirror
    function automatic remap_word_t predict_remap(input kind_t kind,
                                                  input logic [COLOUR_W-1:0] a,
                                                  input logic [COLOUR_W-1:0] b);
        remap_word_t r;
        int          slot;
        fallback_t   ink_fb;
        bit          bright;
        r.first    = a;
        r.second   = b;
        r.replaced = 1'b0;
        r.status   = STATUS_DONE;
        ink_fb     = FALLBACK_NONE;
        case (kind)
            KIND_INSERT: begin
                slot = find_entry(a);
                if (slot >= 0) begin
                    tbl_repl[slot] = b;
                    r.status = STATUS_UPDATED;
                    table_updates++;
                end else if (tbl_used < TABLE_SLOTS) begin
                    tbl_match[tbl_used] = a;
                    tbl_repl[tbl_used]  = b;
                    tbl_used++;
                    r.status = STATUS_APPENDED;
                    table_appends++;
                end else begin
                    r.status = STATUS_FULL;
                    table_drops++;
                end
            end
            KIND_SINGLE, KIND_PAIR: begin
                // ink (or single color) first
                slot = find_entry(a);
                if (slot >= 0) begin
                    r.first    = tbl_repl[slot];
                    r.replaced = 1'b1;
                end else begin
                    ink_fb = pick_fallback(colour_is_light(a), a, r.first);
                    if (ink_fb != FALLBACK_NONE) r.replaced = 1'b1;
                end
                // paper takes the opposite of an ink fallback
                if (kind == KIND_PAIR) begin
                    slot = find_entry(b);
                    if (slot >= 0) begin
                        r.second   = tbl_repl[slot];
                        r.replaced = 1'b1;
                    end else begin
                        if (ink_fb == FALLBACK_DARK) bright = 1'b1;
                        else if (ink_fb == FALLBACK_LIGHT) bright = 1'b0;
                        else bright = colour_is_light(b);
                        if (pick_fallback(bright, b, r.second) != FALLBACK_NONE)
                            r.replaced = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (r.replaced) colours_replaced++;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [COLOUR_W-1:0] want,
                                 input logic [COLOUR_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %08h, got %08h", $time, field, want, got);
        end
    endtask

    // Check each result word against the oldest expectation; stall at random
    always @(posedge aclk) begin
        remap_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none expected, expected none, got %016h / %03b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_words.pop_front();
                compare_field("first_result", want.first, m_tdata[COLOUR_W-1:0]);
                compare_field("second_result", want.second, m_tdata[2*COLOUR_W-1:COLOUR_W]);
                compare_field("was_replaced", 32'(want.replaced), 32'(m_tuser[0]));
                compare_field("status", 32'(want.status), 32'(m_tuser[STATUS_W:1]));
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = idle_len();
        end
    end

    // Offer one word after a random gap; predict it once accepted
    task automatic send_word(input kind_t kind, input logic [COLOUR_W-1:0] first,
                             input logic [COLOUR_W-1:0] second);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {second, first};
        do @(posedge aclk); while (!s_tready);
        expected_words.insert(expected_words.size(), predict_remap(kind, first, second));
        words_sent++;
    endtask

    // Hold off input until every expected word has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
    endtask

    // Write all four fallback registers while the block is idle
    task automatic set_fallbacks(input logic [COLOUR_W-1:0] light_c, input bit light_e,
                                 input logic [COLOUR_W-1:0] dark_c, input bit dark_e);
        cfg_index_t          order  [4];
        logic [COLOUR_W-1:0] values [4];
        order  = '{CFG_LIGHT_COLOUR, CFG_LIGHT_ENABLED, CFG_DARK_COLOUR, CFG_DARK_ENABLED};
        // enable writes carry junk in the upper bits, which must be dropped
        values = '{light_c, ($urandom & 32'hFFFF_FFFE) | 32'(light_e),
                   dark_c, ($urandom & 32'hFFFF_FFFE) | 32'(dark_e)};
        wait_idle();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= values[i];
            @(posedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        light_rgba = light_c;
        light_on   = light_e;
        dark_rgba  = dark_c;
        dark_on    = dark_e;
        settings_written++;
    endtask

    // Random color: extremes, near the brightness threshold, or anything
    function automatic logic [COLOUR_W-1:0] fresh_colour();
        int pick;
        int red;
        int green;
        int blue;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'h0000_0000;
        if (pick == 1) return 32'hFFFF_FFFF;
        if (pick < 5) begin
            red   = $urandom_range(0, 255);
            green = $urandom_range(128, 255);
            blue  = 381 + $urandom_range(0, 3) - red - green;
            if (blue >= 0 && blue <= 255)
                return {red[7:0], green[7:0], blue[7:0], 8'($urandom)};
        end
        return $urandom;
    endfunction

    function automatic logic [COLOUR_W-1:0] pool_or_fresh(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) return colour_pool[$urandom_range(0, POOL_SIZE-1)];
        return fresh_colour();
    endfunction

    // Reset state: empty table, fallbacks off, everything passes through
    task automatic test_passthrough();
        send_word(KIND_SINGLE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(KIND_SINGLE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(KIND_SINGLE, 32'h8080_7F00, 32'h1234_5678);
        send_word(KIND_PAIR,   32'h8080_7F00, 32'h7F80_7FFF);
        send_word(KIND_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Light/dark fallback, threshold edges and the paper inversion
    task automatic test_fallbacks();
        set_fallbacks(32'hF0E0_D0C0, 1'b1, 32'h1020_3040, 1'b1);
        send_word(KIND_SINGLE, 32'h8080_7F00, 32'h0000_0000);
        send_word(KIND_SINGLE, 32'h7F80_7FFF, 32'h0000_0000);
        send_word(KIND_PAIR,   32'h0000_0000, 32'h0101_0101);
        send_word(KIND_PAIR,   32'hFFFF_FFFF, 32'hFEFE_FEFE);
        set_fallbacks(32'hF0E0_D0C0, 1'b1, 32'h1020_3040, 1'b0);
        send_word(KIND_PAIR,   32'h0000_0000, 32'hFFFF_FFFF);
        send_word(KIND_SINGLE, 32'h7F80_7FFF, 32'h0000_0000);
        set_fallbacks(32'hF0E0_D0C0, 1'b0, 32'h1020_3040, 1'b1);
        send_word(KIND_PAIR,   32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Append, update, and lookups that mix table hits with fallbacks
    task automatic test_table_updates();
        set_fallbacks(32'hAAAA_5555, 1'b1, 32'h5555_AAAA, 1'b1);
        send_word(KIND_INSERT, 32'h8080_7F00, 32'h1111_1111);
        send_word(KIND_INSERT, 32'h0000_0000, 32'h2222_2222);
        send_word(KIND_INSERT, 32'h8080_7F00, 32'h3333_3333);
        send_word(KIND_SINGLE, 32'h8080_7F00, 32'h0000_0000);
        send_word(KIND_PAIR,   32'h0000_0000, 32'h8080_7F00);
        send_word(KIND_PAIR,   32'h0000_0000, 32'h7F80_7FFF);
        send_word(KIND_PAIR,   32'hFFFF_FFFF, 32'h0000_0000);
        send_word(KIND_UNUSED, 32'h8080_7F00, 32'h0000_0000);
    endtask

    // Phases of random traffic, each under its own fallback setting
    task automatic test_random_traffic();
        logic [3:0]          mode;
        logic [COLOUR_W-1:0] light_c;
        logic [COLOUR_W-1:0] dark_c;
        logic [COLOUR_W-1:0] a;
        logic [COLOUR_W-1:0] b;
        kind_t               kind;
        int                  roll;
        foreach (colour_pool[i]) colour_pool[i] = fresh_colour();
        for (int phase = 0; phase < 7; phase++) begin
            mode    = 4'(phase + 3);
            light_c = $urandom;
            dark_c  = $urandom;
            if (phase == 0) begin
                light_c = '1;
                dark_c  = '0;
            end
            if (phase == 1) begin
                light_c = '0;
                dark_c  = '1;
            end
            set_fallbacks(light_c, mode[0], dark_c, mode[1]);
            steady = (phase == 2 || phase == 5);
            for (int n = 0; n < 100; n++) begin
                // drain the pipe once in the middle of each phase
                if (n == 50) wait_idle();
                roll = $urandom_range(0, 99);
                if (roll < 20) begin
                    kind = KIND_INSERT;
                    a    = pool_or_fresh(90);
                    b    = $urandom;
                end else begin
                    if (roll < 55) kind = KIND_SINGLE;
                    else if (roll < 95) kind = KIND_PAIR;
                    else kind = KIND_UNUSED;
                    a = pool_or_fresh(60);
                    b = pool_or_fresh(60);
                end
                send_word(kind, a, b);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        tbl_used   = 0;
        light_rgba = '0;
        dark_rgba  = '0;
        light_on   = 1'b0;
        dark_on    = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_passthrough();
        test_fallbacks();
        test_table_updates();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Sent %0d words under %0d fallback settings: %0d appends, %0d updates,",
                 words_sent, settings_written, table_appends, table_updates);
        $display("%0d inserts dropped on a full table, %0d words with a replaced color",
                 table_drops, colours_replaced);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("colour_remap_with_brightness_fallback verification clean");
        end else begin
            $display("colour_remap_with_brightness_fallback verification failed");
        end
        $finish;
    end

endmodule
